// File: hw/rtl/tbfe_pkg.sv
`default_nettype none

package tbfe_pkg;

    localparam int TAP_COUNT = 64;
    localparam int COEF_COUNT = 64;
    localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int FILL_W = $clog2(TAP_COUNT + 1);
    localparam int COEF_IDX_W = $clog2(COEF_COUNT);

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W = 16;
    localparam int CODE_W = 12;
    localparam int ACC_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;
    localparam int ACC_SHIFT = 15;
    localparam int GAIN_SHIFT = 12;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_BASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TREBLE = 2'd2;

    typedef enum logic [1:0] {
        BAND_BASS,
        BAND_MID,
        BAND_TREBLE
    } band_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WAIT,
        OP_START,
        OP_MAC,
        OP_SAT,
        OP_GAIN,
        OP_ACCUM,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_TAP_MORE,
        C_BAND_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT = 3'd0;
    localparam step_t STEP_START = 3'd1;
    localparam step_t STEP_MAC = 3'd2;
    localparam step_t STEP_SAT = 3'd3;
    localparam step_t STEP_GAIN = 3'd4;
    localparam step_t STEP_ACCUM = 3'd5;
    localparam step_t STEP_OUT = 3'd6;

    typedef struct packed {
        op_t op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam logic signed [15:0] COEF_BASS [COEF_COUNT] = '{
        -16'sd47, -16'sd46, -16'sd47, -16'sd48, -16'sd50, -16'sd50, -16'sd49, -16'sd43,
        -16'sd33, -16'sd16, 16'sd9, 16'sd42, 16'sd86, 16'sd140, 16'sd205, 16'sd281,
        16'sd368, 16'sd464, 16'sd569, 16'sd682, 16'sd799, 16'sd920, 16'sd1041, 16'sd1160,
        16'sd1275, 16'sd1382, 16'sd1480, 16'sd1566, 16'sd1637, 16'sd1692, 16'sd1729,
        16'sd1748,
        16'sd1748, 16'sd1729, 16'sd1692, 16'sd1637, 16'sd1566, 16'sd1480, 16'sd1382,
        16'sd1275,
        16'sd1160, 16'sd1041, 16'sd920, 16'sd799, 16'sd682, 16'sd569, 16'sd464, 16'sd368,
        16'sd281, 16'sd205, 16'sd140, 16'sd86, 16'sd42, 16'sd9, -16'sd16, -16'sd33,
        -16'sd43, -16'sd49, -16'sd50, -16'sd50, -16'sd48, -16'sd47, -16'sd46, -16'sd47
    };

    localparam logic signed [15:0] COEF_MID [COEF_COUNT] = '{
        -16'sd35, -16'sd39, -16'sd1, -16'sd3, -16'sd68, -16'sd85, -16'sd13, -16'sd18,
        -16'sd162, -16'sd198, -16'sd40, -16'sd49, -16'sd340, -16'sd399, -16'sd75, -16'sd82,
        -16'sd611, -16'sd695, -16'sd82, -16'sd71, -16'sd988, -16'sd1104, 16'sd25, 16'sd91,
        -16'sd1543, -16'sd1742, 16'sd511, 16'sd800, -16'sd2839, -16'sd3716, 16'sd4084,
        16'sd13944,
        16'sd13944, 16'sd4084, -16'sd3716, -16'sd2839, 16'sd800, 16'sd511, -16'sd1742,
        -16'sd1543,
        16'sd91, 16'sd25, -16'sd1104, -16'sd988, -16'sd71, -16'sd82, -16'sd695, -16'sd611,
        -16'sd82, -16'sd75, -16'sd399, -16'sd340, -16'sd49, -16'sd40, -16'sd198, -16'sd162,
        -16'sd18, -16'sd13, -16'sd85, -16'sd68, -16'sd3, -16'sd1, -16'sd39, -16'sd35
    };

    localparam logic signed [15:0] COEF_TREBLE [COEF_COUNT] = '{
        16'sd20, -16'sd26, -16'sd29, 16'sd28, 16'sd17, 16'sd50, -16'sd121, 16'sd31,
        -16'sd37, 16'sd217, -16'sd130, -16'sd64, -16'sd153, 16'sd217, 16'sd254, -16'sd245,
        -16'sd142, -16'sd398, 16'sd919, -16'sd220, 16'sd254, -16'sd1416, 16'sd822, 16'sd397,
        16'sd935, -16'sd1347, -16'sd1637, 16'sd1696, 16'sd1111, 16'sd3807, -16'sd12805,
        16'sd7993,
        16'sd7993, -16'sd12805, 16'sd3807, 16'sd1111, 16'sd1696, -16'sd1637, -16'sd1347,
        16'sd935,
        16'sd397, 16'sd822, -16'sd1416, 16'sd254, -16'sd220, 16'sd919, -16'sd398, -16'sd142,
        -16'sd245, 16'sd254, 16'sd217, -16'sd153, -16'sd64, -16'sd130, 16'sd217, -16'sd37,
        16'sd31, -16'sd121, 16'sd50, 16'sd17, 16'sd28, -16'sd29, -16'sd26, 16'sd20
    };

    function automatic logic signed [15:0] coef_of(input band_t band, input int tap);
        logic signed [15:0] c;
        c = '0;
        if (tap < COEF_COUNT)
        begin
            unique case (band)
                BAND_BASS:   c = COEF_BASS[tap[COEF_IDX_W-1:0]];
                BAND_MID:    c = COEF_MID[tap[COEF_IDX_W-1:0]];
                BAND_TREBLE: c = COEF_TREBLE[tap[COEF_IDX_W-1:0]];
                default:     c = '0;
            endcase
        end
        return c;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Program: wait for a sample, then per band clear, walk the taps, saturate,
    // scale, and add; finally hand the code to the output register.
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        unique case (step)
            STEP_WAIT:  w = '{op: OP_WAIT,  cond: C_NO_REQ,    target: STEP_WAIT};
            STEP_START: w = '{op: OP_START, cond: C_NEVER,     target: STEP_WAIT};
            STEP_MAC:   w = '{op: OP_MAC,   cond: C_TAP_MORE,  target: STEP_MAC};
            STEP_SAT:   w = '{op: OP_SAT,   cond: C_NEVER,     target: STEP_WAIT};
            STEP_GAIN:  w = '{op: OP_GAIN,  cond: C_NEVER,     target: STEP_WAIT};
            STEP_ACCUM: w = '{op: OP_ACCUM, cond: C_BAND_MORE, target: STEP_START};
            STEP_OUT:   w = '{op: OP_OUT,   cond: C_OUT_BUSY,  target: STEP_OUT};
            default:    w = '{op: OP_NOP,   cond: C_ALWAYS,    target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tbfe_sample_if.sv
`default_nettype none

interface tbfe_sample_if;
    logic valid;
    logic ready;
    logic signed [tbfe_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tbfe_code_if.sv
`default_nettype none

interface tbfe_code_if;
    logic valid;
    logic ready;
    logic [tbfe_pkg::CODE_W-1:0] dac_code;

    modport source (output valid, output dac_code, input ready);
    modport sink (input valid, input dac_code, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tbfe_ram.sv
`default_nettype none

module tbfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_W-1:0]     waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [ADDR_W-1:0]     raddr,
    output logic      [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

`default_nettype wire

// File: hw/rtl/three_band_fir_equalizer.sv
`default_nettype none

// Channel   Dir   Payload             Accepted when
// samples   in    sample_in s16 Q15   samples.valid && samples.ready
// codes     out   dac_code u12        codes.valid && codes.ready
// cfg       in    gain regs s16 Q4.12 cfg_wr_en high at the clock edge
//
// The time until a code is valid is set by the single multiply-accumulate that
// walks every tap once per band; a new request is taken only after the sequencer
// has handed the code to the output register and returned to its wait step.
// After reset all gains are 4096 and a fill count makes the delay line read as zero.
// A finished code waits in the output register while the next request runs;
// the sequencer holds at its output step only while that register is still full and codes.ready is low.

module three_band_fir_equalizer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tbfe_sample_if.sink                             samples,
    tbfe_code_if.source                             codes,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tbfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tbfe_pkg::GAIN_W-1:0]        cfg_data
);
    localparam int TW = tbfe_pkg::TAP_W;
    localparam int FW = tbfe_pkg::FILL_W;

    tbfe_pkg::step_t                    step_reg, step_next;
    tbfe_pkg::ctrl_word_t               cw;
    logic                               jump;

    logic [TW-1:0]                      wp_reg, wp_next;
    logic [TW-1:0]                      rd_ptr_reg, rd_ptr_next;
    logic [TW-1:0]                      tap_reg, tap_next;
    logic [FW-1:0]                      fill_reg, fill_next;
    tbfe_pkg::band_t                    band_reg, band_next;
    logic signed [tbfe_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic signed [15:0]                 band_val_reg, band_val_next;
    logic signed [31:0]                 prod_reg, prod_next;
    logic [15:0]                        sum_reg, sum_next;
    logic signed [15:0]                 gain_bass_reg, gain_bass_next;
    logic signed [15:0]                 gain_mid_reg, gain_mid_next;
    logic signed [15:0]                 gain_treble_reg, gain_treble_next;
    logic                               out_valid_reg, out_valid_next;
    logic [tbfe_pkg::CODE_W-1:0]        dac_reg, dac_next;

    logic                               in_acc;
    logic                               out_busy;
    logic [TW-1:0]                      wp_inc;
    logic [TW-1:0]                      raddr;
    logic [tbfe_pkg::SAMPLE_W-1:0]      rdata;
    logic signed [15:0]                 tap_sample;
    logic signed [15:0]                 tap_coef;
    logic signed [31:0]                 mac_prod;
    logic signed [31:0]                 acc_sh;
    logic signed [31:0]                 gain_q;
    logic signed [15:0]                 gain_sel;
    logic signed [15:0]                 gained;

    function automatic logic [TW-1:0] ptr_dec(input logic [TW-1:0] p);
        return (p == '0) ? TW'(tbfe_pkg::TAP_COUNT - 1) : p - 1'b1;
    endfunction

    assign cw = tbfe_pkg::ucode_rom(step_reg);
    assign out_busy = out_valid_reg && !codes.ready;
    assign in_acc = samples.valid && samples.ready;
    assign wp_inc = (wp_reg == TW'(tbfe_pkg::TAP_COUNT - 1)) ? '0 : wp_reg + 1'b1;

    // Step sequencing.
    always_comb
    begin
        unique case (cw.cond)
            tbfe_pkg::C_NEVER:     jump = 1'b0;
            tbfe_pkg::C_ALWAYS:    jump = 1'b1;
            tbfe_pkg::C_NO_REQ:    jump = !samples.valid;
            tbfe_pkg::C_TAP_MORE:  jump = tap_reg != TW'(tbfe_pkg::TAP_COUNT - 1);
            tbfe_pkg::C_BAND_MORE: jump = band_reg != tbfe_pkg::BAND_TREBLE;
            tbfe_pkg::C_OUT_BUSY:  jump = out_busy;
            default:               jump = 1'b1;
        endcase
        step_next = jump ? cw.target : step_reg + 1'b1;
    end

    // Control word decode toward the ports and the delay-line memory.
    always_comb
    begin
        samples.ready = (cw.op == tbfe_pkg::OP_WAIT);
        codes.valid = out_valid_reg;
        codes.dac_code = dac_reg;
        raddr = (cw.op == tbfe_pkg::OP_START) ? wp_reg : rd_ptr_reg;
    end

    tbfe_ram #(
        .WIDTH (tbfe_pkg::SAMPLE_W),
        .DEPTH (tbfe_pkg::TAP_COUNT)
    ) u_delay (
        .clk   (clk),
        .we    (in_acc),
        .waddr (wp_inc),
        .wdata (samples.sample_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Datapath.
    always_comb
    begin
        tap_sample = (FW'(tap_reg) < fill_reg) ? $signed(rdata) : 16'sd0;
        tap_coef = tbfe_pkg::coef_of(band_reg, int'(tap_reg));
        mac_prod = tap_coef * tap_sample;
        acc_sh = acc_reg >>> tbfe_pkg::ACC_SHIFT;
        gain_q = prod_reg >>> tbfe_pkg::GAIN_SHIFT;
        if (prod_reg[31] && (prod_reg[tbfe_pkg::GAIN_SHIFT-1:0] != '0))
        begin
            gain_q = gain_q + 32'sd1;
        end
        gained = tbfe_pkg::sat16(gain_q);
        unique case (band_reg)
            tbfe_pkg::BAND_BASS:   gain_sel = gain_bass_reg;
            tbfe_pkg::BAND_MID:    gain_sel = gain_mid_reg;
            tbfe_pkg::BAND_TREBLE: gain_sel = gain_treble_reg;
            default:               gain_sel = gain_treble_reg;
        endcase

        wp_next = wp_reg;
        rd_ptr_next = rd_ptr_reg;
        tap_next = tap_reg;
        fill_next = fill_reg;
        band_next = band_reg;
        acc_next = acc_reg;
        band_val_next = band_val_reg;
        prod_next = prod_reg;
        sum_next = sum_reg;
        dac_next = dac_reg;
        out_valid_next = out_valid_reg && !codes.ready;

        unique case (cw.op)
            tbfe_pkg::OP_WAIT:
            begin
                if (in_acc)
                begin
                    wp_next = wp_inc;
                    if (fill_reg != FW'(tbfe_pkg::TAP_COUNT))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    band_next = tbfe_pkg::BAND_BASS;
                    sum_next = '0;
                end
            end
            tbfe_pkg::OP_START:
            begin
                acc_next = '0;
                tap_next = '0;
                rd_ptr_next = ptr_dec(wp_reg);
            end
            tbfe_pkg::OP_MAC:
            begin
                acc_next = acc_reg + mac_prod;
                tap_next = tap_reg + 1'b1;
                rd_ptr_next = ptr_dec(rd_ptr_reg);
            end
            tbfe_pkg::OP_SAT:
            begin
                band_val_next = tbfe_pkg::sat16(acc_sh);
            end
            tbfe_pkg::OP_GAIN:
            begin
                prod_next = band_val_reg * gain_sel;
            end
            tbfe_pkg::OP_ACCUM:
            begin
                sum_next = sum_reg + gained;
                unique case (band_reg)
                    tbfe_pkg::BAND_BASS: band_next = tbfe_pkg::BAND_MID;
                    tbfe_pkg::BAND_MID:  band_next = tbfe_pkg::BAND_TREBLE;
                    default:             band_next = tbfe_pkg::BAND_TREBLE;
                endcase
            end
            tbfe_pkg::OP_OUT:
            begin
                if (!out_busy)
                begin
                    dac_next = {~sum_reg[15], sum_reg[14:4]};
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Gain registers.
    always_comb
    begin
        gain_bass_next = gain_bass_reg;
        gain_mid_next = gain_mid_reg;
        gain_treble_next = gain_treble_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tbfe_pkg::REG_GAIN_BASS:   gain_bass_next = $signed(cfg_data);
                tbfe_pkg::REG_GAIN_MID:    gain_mid_next = $signed(cfg_data);
                tbfe_pkg::REG_GAIN_TREBLE: gain_treble_next = $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= tbfe_pkg::STEP_WAIT;
            wp_reg <= '0;
            fill_reg <= '0;
            band_reg <= tbfe_pkg::BAND_BASS;
            tap_reg <= '0;
            out_valid_reg <= 1'b0;
            gain_bass_reg <= $signed(tbfe_pkg::GAIN_UNITY);
            gain_mid_reg <= $signed(tbfe_pkg::GAIN_UNITY);
            gain_treble_reg <= $signed(tbfe_pkg::GAIN_UNITY);
        end
        else
        begin
            step_reg <= step_next;
            wp_reg <= wp_next;
            fill_reg <= fill_next;
            band_reg <= band_next;
            tap_reg <= tap_next;
            out_valid_reg <= out_valid_next;
            gain_bass_reg <= gain_bass_next;
            gain_mid_reg <= gain_mid_next;
            gain_treble_reg <= gain_treble_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        acc_reg <= acc_next;
        band_val_reg <= band_val_next;
        prod_reg <= prod_next;
        sum_reg <= sum_next;
        dac_reg <= dac_next;
    end
endmodule

`default_nettype wire

// File: hw/rtl/tbfe_checker.sv
`default_nettype none

module tbfe_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [tbfe_pkg::CODE_W-1:0]   dac_code
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Requests taken whose codes have not yet left.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_code_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dac_code))
        else $error("code changed or dropped while stalled");

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("request taken in consecutive cycles");

    a_code_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("code shown with no request outstanding");

    a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two requests outstanding");
endmodule

bind three_band_fir_equalizer tbfe_checker u_tbfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (codes.valid),
    .out_ready (codes.ready),
    .dac_code  (codes.dac_code)
);

`default_nettype wire
